// ===== rtl/core/tdmsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// TDM serial port slot engine package
// Operation codes, interrupt codes, register indexes, status bit positions
// and the configuration bundle shared by the engine's modules.
// ---------------------------------------------------------------------------
package tdmsp_pkg;

   localparam int MaxTxRegs  = 3;
   localparam int SlotBits   = 5;
   localparam int CsrIdxBits = 3;
   localparam int CsrBits    = 5;
   localparam int FlagBits   = 6;

   // Status bit positions.
   localparam int FlagTfs = 0;
   localparam int FlagRfs = 1;
   localparam int FlagTue = 2;
   localparam int FlagRoe = 3;
   localparam int FlagTde = 4;
   localparam int FlagRdf = 5;

   typedef enum logic [2:0] {
      OpWriteTx    = 3'd0,
      OpReadRx     = 3'd1,
      OpTxTick     = 3'd2,
      OpRxTick     = 3'd3,
      OpReadStatus = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      IrqNone  = 2'd0,
      IrqData  = 2'd1,
      IrqError = 2'd2
   } irq_type;

   typedef enum logic [CsrIdxBits-1:0] {
      CsrSlotsMinusOne = 3'd0,
      CsrTxEnables     = 3'd1,
      CsrRxEnable      = 3'd2,
      CsrTxIrqEn       = 3'd3,
      CsrTxLastIrqEn   = 3'd4,
      CsrTxErrIrqEn    = 3'd5,
      CsrRxIrqEn       = 3'd6,
      CsrRxErrIrqEn    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [SlotBits-1:0]  slots_minus_one;
      logic [MaxTxRegs-1:0] tx_enables;
      logic                 rx_enable;
      logic                 tx_irq_en;
      logic                 tx_last_irq_en;
      logic                 tx_err_irq_en;
      logic                 rx_irq_en;
      logic                 rx_err_irq_en;
   } cfg_type;

endpackage
`default_nettype wire

// ===== rtl/core/tdmsp_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// TDM serial port configuration registers
// Write-only control registers for frame length, enables and interrupt
// enables, presented to the engine as one bundle.
// ---------------------------------------------------------------------------
module tdmsp_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [tdmsp_pkg::CsrIdxBits-1:0]    csr_index,
   input  wire logic [tdmsp_pkg::CsrBits-1:0]       csr_write_data,
   output tdmsp_pkg::cfg_type                       cfg
);

   tdmsp_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (tdmsp_pkg::csr_index_type'(csr_index))
            tdmsp_pkg::CsrSlotsMinusOne: cfg_in.slots_minus_one = csr_write_data;
            tdmsp_pkg::CsrTxEnables:
               cfg_in.tx_enables = csr_write_data[tdmsp_pkg::MaxTxRegs-1:0];
            tdmsp_pkg::CsrRxEnable:    cfg_in.rx_enable      = csr_write_data[0];
            tdmsp_pkg::CsrTxIrqEn:     cfg_in.tx_irq_en      = csr_write_data[0];
            tdmsp_pkg::CsrTxLastIrqEn: cfg_in.tx_last_irq_en = csr_write_data[0];
            tdmsp_pkg::CsrTxErrIrqEn:  cfg_in.tx_err_irq_en  = csr_write_data[0];
            tdmsp_pkg::CsrRxIrqEn:     cfg_in.rx_irq_en      = csr_write_data[0];
            tdmsp_pkg::CsrRxErrIrqEn:  cfg_in.rx_err_irq_en  = csr_write_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/core/tdmsp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// TDM serial port slot state
// Holds the data registers, flags and slot counters, and works out the
// result of one request combinationally; state advances when step is high.
// ---------------------------------------------------------------------------
module tdmsp_core #(
   parameter int WORD_BITS = 24,
   parameter int TX_REGS   = 3
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tdmsp_pkg::cfg_type    cfg,
   input  wire logic                  step,
   input  wire logic [2:0]            operation,
   input  wire logic [1:0]            slot_select,
   input  wire logic [WORD_BITS-1:0]  data_word,
   output logic [WORD_BITS-1:0]       read_data,
   output logic                       slot_valid,
   output logic [WORD_BITS-1:0]       slot_word_0,
   output logic [WORD_BITS-1:0]       slot_word_1,
   output logic [WORD_BITS-1:0]       slot_word_2,
   output logic                       first_slot,
   output logic                       frame_end,
   output tdmsp_pkg::irq_type         tx_irq,
   output logic                       tx_last_irq,
   output tdmsp_pkg::irq_type         rx_irq,
   output logic                       rx_dma_request
);

   localparam logic [1:0] SelLimit = 2'(TX_REGS);
   localparam logic [tdmsp_pkg::FlagBits-1:0] FlagsReset =
      tdmsp_pkg::FlagBits'((1 << tdmsp_pkg::FlagTde) | (1 << tdmsp_pkg::FlagTfs));

   logic [WORD_BITS-1:0]                tx_words_ff [TX_REGS];
   logic [WORD_BITS-1:0]                tx_words_in [TX_REGS];
   logic [WORD_BITS-1:0]                rx_word_ff, rx_word_in;
   logic [TX_REGS-1:0]                  written_ff, written_in;
   logic [tdmsp_pkg::FlagBits-1:0]      flags_ff, flags_in;
   logic                                unread_ff, unread_in;
   logic [tdmsp_pkg::SlotBits-1:0]      tx_count_ff, tx_count_in;
   logic [tdmsp_pkg::SlotBits-1:0]      rx_count_ff, rx_count_in;
   logic [TX_REGS-1:0]                  en;
   logic [WORD_BITS-1:0]                slot_words [tdmsp_pkg::MaxTxRegs];

   assign en = cfg.tx_enables[TX_REGS-1:0];

   always_comb begin
      tx_words_in    = tx_words_ff;
      rx_word_in     = rx_word_ff;
      written_in     = written_ff;
      flags_in       = flags_ff;
      unread_in      = unread_ff;
      tx_count_in    = tx_count_ff;
      rx_count_in    = rx_count_ff;
      read_data      = '0;
      slot_valid     = 1'b0;
      first_slot     = 1'b0;
      frame_end      = 1'b0;
      tx_irq         = tdmsp_pkg::IrqNone;
      tx_last_irq    = 1'b0;
      rx_irq         = tdmsp_pkg::IrqNone;
      rx_dma_request = 1'b0;
      for (int k = 0; k < tdmsp_pkg::MaxTxRegs; k++) begin
         slot_words[k] = '0;
      end

      case (tdmsp_pkg::op_type'(operation))
         tdmsp_pkg::OpWriteTx: begin
            if (slot_select < SelLimit) begin
               for (int j = 0; j < TX_REGS; j++) begin
                  if (slot_select == 2'(j)) begin
                     tx_words_in[j] = data_word;
                     written_in[j]  = 1'b1;
                  end
               end
               if (written_in == en) begin
                  flags_in[tdmsp_pkg::FlagTue] = 1'b0;
                  flags_in[tdmsp_pkg::FlagTde] = 1'b0;
               end
            end
         end
         tdmsp_pkg::OpReadRx: begin
            if (cfg.rx_enable) begin
               unread_in = 1'b0;
               flags_in[tdmsp_pkg::FlagRdf] = 1'b0;
               flags_in[tdmsp_pkg::FlagRoe] = 1'b0;
               read_data = rx_word_ff;
            end
         end
         tdmsp_pkg::OpTxTick: begin
            if (en != '0) begin
               slot_valid = 1'b1;
               for (int j = 0; j < TX_REGS; j++) begin
                  slot_words[j] = tx_words_ff[j];
               end
               if ((written_ff & en) != en) begin
                  flags_in[tdmsp_pkg::FlagTue] = 1'b1;
               end
               flags_in[tdmsp_pkg::FlagTde] = 1'b1;
               written_in = '0;
               first_slot = (tx_count_ff == '0);
               flags_in[tdmsp_pkg::FlagTfs] = first_slot;
               // A frame length lowered under the running count also ends the frame.
               if (tx_count_ff >= cfg.slots_minus_one) begin
                  frame_end   = 1'b1;
                  tx_count_in = '0;
                  tx_last_irq = cfg.tx_last_irq_en;
               end else begin
                  tx_count_in = tx_count_ff + 1'b1;
               end
               if (flags_in[tdmsp_pkg::FlagTue] && cfg.tx_err_irq_en) begin
                  tx_irq = tdmsp_pkg::IrqError;
                  flags_in[tdmsp_pkg::FlagTue] = 1'b0;
               end else if (cfg.tx_irq_en) begin
                  tx_irq = tdmsp_pkg::IrqData;
               end
            end
         end
         tdmsp_pkg::OpRxTick: begin
            if (cfg.rx_enable) begin
               if (unread_ff) begin
                  flags_in[tdmsp_pkg::FlagRoe] = 1'b1;
               end
               rx_word_in     = data_word;
               unread_in      = 1'b1;
               flags_in[tdmsp_pkg::FlagRdf] = 1'b1;
               rx_dma_request = 1'b1;
               flags_in[tdmsp_pkg::FlagRfs] = (rx_count_ff == '0);
               if (flags_in[tdmsp_pkg::FlagRoe] && cfg.rx_err_irq_en) begin
                  rx_irq = tdmsp_pkg::IrqError;
                  flags_in[tdmsp_pkg::FlagRoe] = 1'b0;
               end else if (cfg.rx_irq_en) begin
                  rx_irq = tdmsp_pkg::IrqData;
               end
               if (rx_count_ff >= cfg.slots_minus_one) begin
                  rx_count_in = '0;
               end else begin
                  rx_count_in = rx_count_ff + 1'b1;
               end
            end
         end
         tdmsp_pkg::OpReadStatus: begin
            read_data = WORD_BITS'(flags_ff);
         end
         default: begin
            read_data = '0;
         end
      endcase
   end

   assign slot_word_0 = slot_words[0];
   assign slot_word_1 = slot_words[1];
   assign slot_word_2 = slot_words[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < TX_REGS; j++) begin
            tx_words_ff[j] <= '0;
         end
         rx_word_ff  <= '0;
         written_ff  <= '0;
         flags_ff    <= FlagsReset;
         unread_ff   <= 1'b0;
         tx_count_ff <= '0;
         rx_count_ff <= '0;
      end else if (step) begin
         tx_words_ff <= tx_words_in;
         rx_word_ff  <= rx_word_in;
         written_ff  <= written_in;
         flags_ff    <= flags_in;
         unread_ff   <= unread_in;
         tx_count_ff <= tx_count_in;
         rx_count_ff <= rx_count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/tdm_serial_port_slot_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// TDM serial port slot engine
// Time-division serial port with transmit data registers, a receive register,
// status flags, slot counters and interrupt outcomes, one result per request.
// ---------------------------------------------------------------------------
// The engine takes one request per clock while req_stall is low and returns
// exactly one response for it: the request is captured in an input
// register, the flag, counter and data-register update is worked out in one
// pass of logic, and the response is held in an output register. While the
// response side stalls, the input register still takes one more request, so
// throughput is one request per cycle whenever the response side keeps up.
// Configuration registers must only be written while no request is in flight.
module tdm_serial_port_slot_engine #(
   parameter int WORD_BITS = 24,
   parameter int TX_REGS   = 3
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [tdmsp_pkg::CsrIdxBits-1:0]   csr_index,
   input  wire logic [tdmsp_pkg::CsrBits-1:0]      csr_write_data,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [2:0]                         req_operation,
   input  wire logic [1:0]                         req_slot_select,
   input  wire logic [WORD_BITS-1:0]               req_data_word,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [WORD_BITS-1:0]                    rsp_read_data,
   output logic                                    rsp_slot_valid,
   output logic [WORD_BITS-1:0]                    rsp_slot_word_0,
   output logic [WORD_BITS-1:0]                    rsp_slot_word_1,
   output logic [WORD_BITS-1:0]                    rsp_slot_word_2,
   output logic                                    rsp_first_slot,
   output logic                                    rsp_frame_end,
   output logic [1:0]                              rsp_tx_irq,
   output logic                                    rsp_tx_last_irq,
   output logic [1:0]                              rsp_rx_irq,
   output logic                                    rsp_rx_dma_request
);

   tdmsp_pkg::cfg_type cfg;

   logic                  in_valid_ff, in_valid_in;
   logic [2:0]            in_op_ff;
   logic [1:0]            in_sel_ff;
   logic [WORD_BITS-1:0]  in_data_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  advance, step, req_take;

   logic [WORD_BITS-1:0]  nx_read_data, nx_w0, nx_w1, nx_w2;
   logic                  nx_slot_valid, nx_first, nx_end, nx_last_irq, nx_dma;
   tdmsp_pkg::irq_type    nx_tx_irq, nx_rx_irq;

   logic [WORD_BITS-1:0]  read_data_ff, w0_ff, w1_ff, w2_ff;
   logic                  slot_valid_ff, first_ff, end_ff, last_irq_ff, dma_ff;
   logic [1:0]            tx_irq_ff, rx_irq_ff;

   tdmsp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   tdmsp_core #(
      .WORD_BITS (WORD_BITS),
      .TX_REGS   (TX_REGS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .step           (step),
      .operation      (in_op_ff),
      .slot_select    (in_sel_ff),
      .data_word      (in_data_ff),
      .read_data      (nx_read_data),
      .slot_valid     (nx_slot_valid),
      .slot_word_0    (nx_w0),
      .slot_word_1    (nx_w1),
      .slot_word_2    (nx_w2),
      .first_slot     (nx_first),
      .frame_end      (nx_end),
      .tx_irq         (nx_tx_irq),
      .tx_last_irq    (nx_last_irq),
      .rx_irq         (nx_rx_irq),
      .rx_dma_request (nx_dma)
   );

   // The output register can take a new response when empty or being drained.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_operation;
         in_sel_ff  <= req_slot_select;
         in_data_ff <= req_data_word;
      end
      if (step) begin
         read_data_ff  <= nx_read_data;
         slot_valid_ff <= nx_slot_valid;
         w0_ff         <= nx_w0;
         w1_ff         <= nx_w1;
         w2_ff         <= nx_w2;
         first_ff      <= nx_first;
         end_ff        <= nx_end;
         tx_irq_ff     <= nx_tx_irq;
         last_irq_ff   <= nx_last_irq;
         rx_irq_ff     <= nx_rx_irq;
         dma_ff        <= nx_dma;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_read_data      = read_data_ff;
   assign rsp_slot_valid     = slot_valid_ff;
   assign rsp_slot_word_0    = w0_ff;
   assign rsp_slot_word_1    = w1_ff;
   assign rsp_slot_word_2    = w2_ff;
   assign rsp_first_slot     = first_ff;
   assign rsp_frame_end      = end_ff;
   assign rsp_tx_irq         = tx_irq_ff;
   assign rsp_tx_last_irq    = last_irq_ff;
   assign rsp_rx_irq         = rx_irq_ff;
   assign rsp_rx_dma_request = dma_ff;

   // A response only appears after a request left the input register.
   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(step))
      else $error("response appeared without a processed request");

   // Slot markers only accompany an emitted transmit slot.
   a_markers_need_slot: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (first_ff || end_ff || last_irq_ff)) |-> slot_valid_ff)
      else $error("slot marker without a transmit slot");

   // A request held in the input register is not lost while the output stalls.
   a_held_request_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step) |=> in_valid_ff)
      else $error("held request dropped");

   // A transmit tick and a receive tick never share a response.
   a_one_direction: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(slot_valid_ff && dma_ff))
      else $error("transmit and receive outcome in one response");

endmodule
`default_nettype wire

// ===== test/tb_tdm_serial_port_slot_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDM serial port slot engine testbench
// Drives register writes, receive reads, slot ticks and status reads under a
// series of port settings, with sender bursts and gaps and receiver stalls.
// A shadow of the port's registers, flags and slot counters predicts each
// response, and every accepted response is compared field by field.
// ----------------------------------------------------------------------------
module tb_tdm_serial_port_slot_engine;
   import tdmsp_pkg::*;

   localparam int WordBits   = 24;
   localparam int TxRegs     = 3;
   localparam int CycleLimit = 300000;
   localparam int LongHold   = 200;
   localparam int PhaseCount = 12;
   localparam int PhaseItems = 165;

   // Operation codes that the port does not define.
   localparam logic [2:0] OpSpareA = 3'd5;
   localparam logic [2:0] OpSpareB = 3'd6;
   localparam logic [2:0] OpSpareC = 3'd7;
   // A slot select that addresses no transmit register.
   localparam logic [1:0] SelAbsent = 2'd3;

   typedef logic [WordBits-1:0] word_type;

   typedef struct {
      word_type read_data;
      logic     slot_valid;
      word_type slot_word_0;
      word_type slot_word_1;
      word_type slot_word_2;
      logic     first_slot;
      logic     frame_end;
      irq_type  tx_irq;
      logic     tx_last_irq;
      irq_type  rx_irq;
      logic     rx_dma_request;
   } port_response_type;

   // Shadow copy of the port: predicts the response of each accepted request
   // and holds the predictions until the matching response arrives.
   class port_shadow;
      cfg_type             cfg;
      word_type            tx_word [TxRegs];
      word_type            rx_word;
      logic [TxRegs-1:0]   written;
      logic [FlagBits-1:0] flags;
      logic                rx_unread;
      logic [SlotBits-1:0] tx_count;
      logic [SlotBits-1:0] rx_count;
      port_response_type   awaited [$];
      int                  mismatches;

      function new();
         cfg = '0;
         foreach (tx_word[i]) tx_word[i] = '0;
         rx_word = '0;
         written = '0;
         flags = '0;
         flags[FlagTde] = 1'b1;
         flags[FlagTfs] = 1'b1;
         rx_unread = 1'b0;
         tx_count = '0;
         rx_count = '0;
         mismatches = 0;
      endfunction

      function void write_csr(csr_index_type idx, logic [CsrBits-1:0] value);
         case (idx)
            CsrSlotsMinusOne: cfg.slots_minus_one = value[SlotBits-1:0];
            CsrTxEnables:     cfg.tx_enables = value[MaxTxRegs-1:0];
            CsrRxEnable:      cfg.rx_enable = value[0];
            CsrTxIrqEn:       cfg.tx_irq_en = value[0];
            CsrTxLastIrqEn:   cfg.tx_last_irq_en = value[0];
            CsrTxErrIrqEn:    cfg.tx_err_irq_en = value[0];
            CsrRxIrqEn:       cfg.rx_irq_en = value[0];
            CsrRxErrIrqEn:    cfg.rx_err_irq_en = value[0];
            default: ;
         endcase
      endfunction

      function void absorb_request(logic [2:0] op, logic [1:0] sel, word_type data);
         port_response_type r;
         logic [TxRegs-1:0] en;
         r.read_data = '0;
         r.slot_valid = 1'b0;
         r.slot_word_0 = '0;
         r.slot_word_1 = '0;
         r.slot_word_2 = '0;
         r.first_slot = 1'b0;
         r.frame_end = 1'b0;
         r.tx_irq = IrqNone;
         r.tx_last_irq = 1'b0;
         r.rx_irq = IrqNone;
         r.rx_dma_request = 1'b0;
         en = cfg.tx_enables;
         case (op)
            OpWriteTx: begin
               if (sel < TxRegs) begin
                  tx_word[sel] = data;
                  written[sel] = 1'b1;
                  if (written == en) begin
                     flags[FlagTue] = 1'b0;
                     flags[FlagTde] = 1'b0;
                  end
               end
            end
            OpReadRx: begin
               if (cfg.rx_enable) begin
                  rx_unread = 1'b0;
                  flags[FlagRdf] = 1'b0;
                  flags[FlagRoe] = 1'b0;
                  r.read_data = rx_word;
               end
            end
            OpTxTick: begin
               if (en != '0) begin
                  r.slot_valid = 1'b1;
                  r.slot_word_0 = tx_word[0];
                  r.slot_word_1 = tx_word[1];
                  r.slot_word_2 = tx_word[2];
                  if ((written & en) != en) flags[FlagTue] = 1'b1;
                  flags[FlagTde] = 1'b1;
                  written = '0;
                  flags[FlagTfs] = (tx_count == '0);
                  r.first_slot = (tx_count == '0);
                  // A frame shortened below the current count ends at once.
                  if (tx_count >= cfg.slots_minus_one) begin
                     r.frame_end = 1'b1;
                     tx_count = '0;
                     r.tx_last_irq = cfg.tx_last_irq_en;
                  end else begin
                     tx_count = tx_count + 1'b1;
                  end
                  if (flags[FlagTue] && cfg.tx_err_irq_en) begin
                     r.tx_irq = IrqError;
                     flags[FlagTue] = 1'b0;
                  end else if (cfg.tx_irq_en) begin
                     r.tx_irq = IrqData;
                  end
               end
            end
            OpRxTick: begin
               if (cfg.rx_enable) begin
                  if (rx_unread) flags[FlagRoe] = 1'b1;
                  rx_word = data;
                  rx_unread = 1'b1;
                  flags[FlagRdf] = 1'b1;
                  r.rx_dma_request = 1'b1;
                  flags[FlagRfs] = (rx_count == '0);
                  if (flags[FlagRoe] && cfg.rx_err_irq_en) begin
                     r.rx_irq = IrqError;
                     flags[FlagRoe] = 1'b0;
                  end else if (cfg.rx_irq_en) begin
                     r.rx_irq = IrqData;
                  end
                  if (rx_count >= cfg.slots_minus_one) rx_count = '0;
                  else rx_count = rx_count + 1'b1;
               end
            end
            OpReadStatus: r.read_data = word_type'(flags);
            default: ;
         endcase
         awaited.push_back(r);
      endfunction

      function void compare_field(string name, word_type want, word_type got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void match_response(port_response_type got);
         port_response_type want;
         if (awaited.size() == 0) begin
            $error("response arrived with no request outstanding");
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("slot_valid", word_type'(want.slot_valid),
                       word_type'(got.slot_valid));
         compare_field("slot_word_0", want.slot_word_0, got.slot_word_0);
         compare_field("slot_word_1", want.slot_word_1, got.slot_word_1);
         compare_field("slot_word_2", want.slot_word_2, got.slot_word_2);
         compare_field("first_slot", word_type'(want.first_slot),
                       word_type'(got.first_slot));
         compare_field("frame_end", word_type'(want.frame_end),
                       word_type'(got.frame_end));
         compare_field("tx_irq", word_type'(want.tx_irq), word_type'(got.tx_irq));
         compare_field("tx_last_irq", word_type'(want.tx_last_irq),
                       word_type'(got.tx_last_irq));
         compare_field("rx_irq", word_type'(want.rx_irq), word_type'(got.rx_irq));
         compare_field("rx_dma_request", word_type'(want.rx_dma_request),
                       word_type'(got.rx_dma_request));
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CsrIdxBits-1:0] csr_index = '0;
   logic [CsrBits-1:0]    csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [2:0]            req_operation = '0;
   logic [1:0]            req_slot_select = '0;
   word_type              req_data_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   word_type              rsp_read_data;
   logic                  rsp_slot_valid;
   word_type              rsp_slot_word_0;
   word_type              rsp_slot_word_1;
   word_type              rsp_slot_word_2;
   logic                  rsp_first_slot;
   logic                  rsp_frame_end;
   logic [1:0]            rsp_tx_irq;
   logic                  rsp_tx_last_irq;
   logic [1:0]            rsp_rx_irq;
   logic                  rsp_rx_dma_request;

   port_shadow shadow = new();
   bit         hold_off_pending = 1'b0;
   bit         gaps_on = 1'b1;
   int         burst_left = 0;
   int         requests_sent = 0;

   tdm_serial_port_slot_engine #(
      .WORD_BITS(WordBits),
      .TX_REGS  (TxRegs)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_slot_select   (req_slot_select),
      .req_data_word     (req_data_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_slot_valid    (rsp_slot_valid),
      .rsp_slot_word_0   (rsp_slot_word_0),
      .rsp_slot_word_1   (rsp_slot_word_1),
      .rsp_slot_word_2   (rsp_slot_word_2),
      .rsp_first_slot    (rsp_first_slot),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_tx_irq        (rsp_tx_irq),
      .rsp_tx_last_irq   (rsp_tx_last_irq),
      .rsp_rx_irq        (rsp_rx_irq),
      .rsp_rx_dma_request(rsp_rx_dma_request)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      int cycles;
      for (cycles = 0; cycles < CycleLimit; cycles++) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   // Receiver stalls: random modes over random spans, plus a long hold-off on demand.
   initial begin : response_stall
      int mode;
      int span;
      int k;
      mode = 0;
      span = 0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            for (k = 1; k < LongHold; k++) @(posedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(20, 150);
            end
            span--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ((span % 8) < 3);
            endcase
         end
      end
   end

   // Outputs are stable at the falling edge, so a response seen here with
   // stall low is the one taken at the next rising edge.
   always @(negedge clock) begin : response_check
      port_response_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         got.read_data = rsp_read_data;
         got.slot_valid = rsp_slot_valid;
         got.slot_word_0 = rsp_slot_word_0;
         got.slot_word_1 = rsp_slot_word_1;
         got.slot_word_2 = rsp_slot_word_2;
         got.first_slot = rsp_first_slot;
         got.frame_end = rsp_frame_end;
         got.tx_irq = irq_type'(rsp_tx_irq);
         got.tx_last_irq = rsp_tx_last_irq;
         got.rx_irq = irq_type'(rsp_rx_irq);
         got.rx_dma_request = rsp_rx_dma_request;
         shadow.match_response(got);
      end
   end

   function automatic word_type any_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return word_type'($urandom());
      endcase
   endfunction

   // Offers one request and returns at the rising edge that accepts it.
   task automatic send(input logic [2:0] op, input logic [1:0] sel, input word_type data);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_operation <= op;
      req_slot_select <= sel;
      req_data_word <= data;
      do @(negedge clock); while (req_stall !== 1'b0);
      @(posedge clock);
      shadow.absorb_request(op, sel, data);
      requests_sent++;
   endtask

   // Lets every outstanding request come back so the port is idle.
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (shadow.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_csr(input csr_index_type idx, input logic [CsrBits-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      shadow.write_csr(idx, value);
   endtask

   task automatic program_port(input cfg_type c);
      put_csr(CsrSlotsMinusOne, CsrBits'(c.slots_minus_one));
      put_csr(CsrTxEnables, CsrBits'(c.tx_enables));
      put_csr(CsrRxEnable, CsrBits'(c.rx_enable));
      put_csr(CsrTxIrqEn, CsrBits'(c.tx_irq_en));
      put_csr(CsrTxLastIrqEn, CsrBits'(c.tx_last_irq_en));
      put_csr(CsrTxErrIrqEn, CsrBits'(c.tx_err_irq_en));
      put_csr(CsrRxIrqEn, CsrBits'(c.rx_irq_en));
      put_csr(CsrRxErrIrqEn, CsrBits'(c.rx_err_irq_en));
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      cfg_type c;
      int phase;
      int mark;
      int skip;
      int rot;
      int k;
      int r;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Everything disabled after reset: ticks and receive reads do nothing.
      send(OpReadStatus, 2'd0, '0);
      send(OpTxTick, 2'd0, '0);
      send(OpRxTick, 2'd0, '1);
      send(OpReadRx, 2'd0, '0);
      send(OpSpareA, SelAbsent, '1);
      send(OpSpareB, 2'd1, '1);
      send(OpSpareC, 2'd2, '0);
      send(OpWriteTx, SelAbsent, '1);
      send(OpWriteTx, 2'd0, 24'h123456);
      settle();

      // Longest frame, all registers and interrupts on.
      c = '0;
      c.slots_minus_one = '1;
      c.tx_enables = '1;
      c.rx_enable = 1'b1;
      c.tx_irq_en = 1'b1;
      c.tx_last_irq_en = 1'b1;
      c.tx_err_irq_en = 1'b1;
      c.rx_irq_en = 1'b1;
      c.rx_err_irq_en = 1'b1;
      program_port(c);
      send(OpWriteTx, 2'd0, '0);
      send(OpWriteTx, 2'd1, '1);
      send(OpWriteTx, 2'd2, 24'hA5A5A5);
      send(OpReadStatus, 2'd0, '0);
      send(OpTxTick, 2'd0, '0);
      send(OpTxTick, 2'd0, '0);
      send(OpReadStatus, 2'd0, '0);
      send(OpRxTick, 2'd0, '1);
      send(OpRxTick, 2'd0, '0);
      send(OpReadRx, 2'd0, '0);
      send(OpReadStatus, 2'd0, '0);
      settle();

      // One-slot frame entered with the count already past it.
      c.slots_minus_one = '0;
      c.tx_enables = 3'b100;
      c.tx_irq_en = 1'b0;
      c.tx_err_irq_en = 1'b0;
      c.rx_err_irq_en = 1'b0;
      program_port(c);
      send(OpWriteTx, 2'd2, '1);
      send(OpTxTick, 2'd0, '0);
      send(OpTxTick, 2'd0, '0);
      send(OpReadStatus, 2'd0, '0);
      settle();

      for (phase = 0; phase < PhaseCount; phase++) begin
         case (phase % 4)
            0: c.slots_minus_one = '0;
            1: c.slots_minus_one = '1;
            default: begin
               if ($urandom_range(0, 3) == 0)
                  c.slots_minus_one = SlotBits'($urandom_range(0, 31));
               else c.slots_minus_one = SlotBits'($urandom_range(1, 6));
            end
         endcase
         if (phase == 5) c.tx_enables = '0;
         else if (phase % 3 == 0) c.tx_enables = '1;
         else c.tx_enables = MaxTxRegs'($urandom_range(1, 7));
         c.rx_enable = (phase == 7) ? 1'b0 : ($urandom_range(0, 5) != 0);
         c.tx_irq_en = 1'($urandom_range(0, 1));
         c.tx_last_irq_en = 1'($urandom_range(0, 1));
         c.tx_err_irq_en = 1'($urandom_range(0, 1));
         c.rx_irq_en = 1'($urandom_range(0, 1));
         c.rx_err_irq_en = 1'($urandom_range(0, 1));
         program_port(c);

         gaps_on = ($urandom_range(0, 3) != 0);
         // Hold the response side off and keep offering so the port backs up.
         if (phase == 3 || phase == 9) begin
            hold_off_pending = 1'b1;
            gaps_on = 1'b0;
         end

         mark = requests_sent;
         while (requests_sent - mark < PhaseItems) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  // Fill the enabled registers, now and then leaving one out, then tick.
                  skip = ($urandom_range(0, 7) == 0) ? $urandom_range(0, TxRegs - 1) : TxRegs;
                  rot = $urandom_range(0, TxRegs - 1);
                  for (k = 0; k < TxRegs; k++) begin
                     r = (k + rot) % TxRegs;
                     if (c.tx_enables[r] && r != skip) send(OpWriteTx, 2'(r), any_word());
                  end
                  if ($urandom_range(0, 5) == 0)
                     send(OpWriteTx, 2'($urandom_range(0, 3)), any_word());
                  send(OpTxTick, 2'($urandom_range(0, 3)), any_word());
               end
               4, 5, 6: begin
                  send(OpRxTick, 2'($urandom_range(0, 3)), any_word());
                  if ($urandom_range(0, 3) != 0)
                     send(OpReadRx, 2'($urandom_range(0, 3)), any_word());
               end
               7: send(OpReadStatus, 2'($urandom_range(0, 3)), any_word());
               default: send(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), any_word());
            endcase
         end
         settle();
      end

      repeat (16) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
